@@ hw/rtl/ctlt_pkg.sv @@
// ctlt_pkg: shared field widths, opcode, status and sequencer state types,
// and the address fold used to pick a lock token
// no dependencies
package ctlt_pkg;

    localparam int OP_W     = 2;
    localparam int CPU_W    = 3;
    localparam int ADDR_W   = 48;
    localparam int STATUS_W = 3;
    localparam int TOKEN_W  = 6;
    localparam int OWNER_W  = 4;
    localparam int COUNT_W  = 5;

    localparam int FOLD_SHIFT_A = 6;
    localparam int FOLD_SHIFT_B = 12;
    localparam int FOLD_SHIFT_C = 18;
    localparam int FOLD_SHIFT_D = 24;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE     = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_RELEASE_ALL = 2'd2,
        OP_QUERY       = 2'd3
    } ctlt_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED      = 3'd0,
        ST_HELD         = 3'd1,
        ST_BUSY         = 3'd2,
        ST_RELEASED     = 3'd3,
        ST_NOT_OWNER    = 3'd4,
        ST_LIST_FULL    = 3'd5,
        ST_NULL_ADDR    = 3'd6,
        ST_ALL_RELEASED = 3'd7
    } ctlt_status_t;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2,
        S_SWEEP = 2'd3
    } ctlt_state_t;

    // xor fold of the address, caller keeps the low index bits
    function automatic logic [ADDR_W-1:0] fold_addr(input logic [ADDR_W-1:0] addr);
        return (addr >> FOLD_SHIFT_A) ^ (addr >> FOLD_SHIFT_B)
             ^ (addr >> FOLD_SHIFT_C) ^ (addr >> FOLD_SHIFT_D);
    endfunction

endpackage

@@ hw/rtl/ctlt_req_if.sv @@
// ctlt_req_if: request channel, valid/ready with opcode, cpu and address
// depends on ctlt_pkg
interface ctlt_req_if;
    logic                          valid;
    logic                          ready;
    logic [ctlt_pkg::OP_W-1:0]     opcode;
    logic [ctlt_pkg::CPU_W-1:0]    cpu_number;
    logic [ctlt_pkg::ADDR_W-1:0]   resource_address;

    modport source (output valid, output opcode, output cpu_number,
                    output resource_address, input ready);
    modport sink   (input valid, input opcode, input cpu_number,
                    input resource_address, output ready);
endinterface

@@ hw/rtl/ctlt_rsp_if.sv @@
// ctlt_rsp_if: response channel, valid/ready with status and token fields
// depends on ctlt_pkg
interface ctlt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ctlt_pkg::STATUS_W-1:0]  status;
    logic [ctlt_pkg::TOKEN_W-1:0]   token_index;
    logic [ctlt_pkg::OWNER_W-1:0]   current_owner;
    logic [ctlt_pkg::COUNT_W-1:0]   released_count;
    logic                           is_holding;

    modport source (output valid, output status, output token_index,
                    output current_owner, output released_count,
                    output is_holding, input ready);
    modport sink   (input valid, input status, input token_index,
                    input current_owner, input released_count,
                    input is_holding, output ready);
endinterface

@@ hw/rtl/ctlt_ram.sv @@
// ctlt_ram: generic single write port, single read port ram, registered read
// no dependencies
module ctlt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/cpu_token_lock_table.sv @@
// cpu_token_lock_table: lock token table with per cpu hold counts
// depends on ctlt_pkg, ctlt_req_if, ctlt_rsp_if, ctlt_ram
//
// usage
//   req carries one lock request per beat: opcode (acquire, release,
//   release all, query), cpu number and resource address. the address is
//   xor folded into a token index. rsp returns one result beat per request:
//   status, token index, owner after the request, freed count, holding flag.
//   a single token request reads the owner ram in its accept cycle
//   (registered read port), then decides and writes back in the decide
//   state. a new request is taken only back in idle, so the block does not
//   take a request before it is through with the last one.
//   release all walks the owner ram one entry per cycle through the same
//   read port before its decide state; for a cpu number outside the pool
//   of cpus it skips the walk and goes straight to the decide state.
//   after reset a clearing pass writes every owner entry free, with
//   req.ready low all the while.
//   the result sits in an output register; while it waits the block goes
//   on to take the next request, and only stalls in its decide cycle if the
//   previous result is still not taken by then.
module cpu_token_lock_table #(
    parameter int POOL_SIZE = 64,
    parameter int CPU_COUNT = 8,
    parameter int MAX_HELD  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    ctlt_req_if.sink          req,
    ctlt_rsp_if.source        rsp
);

    localparam int IDX_W  = $clog2(POOL_SIZE);
    localparam int CNT_W  = $clog2(POOL_SIZE + 1);
    localparam int OWN_W  = $clog2(CPU_COUNT + 1);
    localparam int HELD_W = $clog2(MAX_HELD + 1);
    localparam int CPU_IW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    localparam logic [OWN_W-1:0]  FREE_MARK = OWN_W'(CPU_COUNT);
    localparam logic [CNT_W-1:0]  POOL_END  = CNT_W'(POOL_SIZE);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(POOL_SIZE - 1);
    localparam logic [HELD_W-1:0] HELD_MAX  = HELD_W'(MAX_HELD);
    localparam int                REL_SAT   = (1 << ctlt_pkg::COUNT_W) - 1;

    // sequencer and request registers
    ctlt_pkg::ctlt_state_t          state_reg, state_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]               chk_addr_reg, chk_addr_next;
    ctlt_pkg::ctlt_op_t             op_reg, op_next;
    logic [ctlt_pkg::CPU_W-1:0]     cpu_reg, cpu_next;
    logic                           cpu_ok_reg, cpu_ok_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic                           null_reg, null_next;
    logic [CNT_W-1:0]               rel_reg, rel_next;
    logic [HELD_W-1:0]              held_reg [CPU_COUNT];
    logic [HELD_W-1:0]              held_next [CPU_COUNT];

    // output register
    logic                           out_valid_reg, out_valid_next;
    ctlt_pkg::ctlt_status_t         out_status_reg, out_status_next;
    logic [ctlt_pkg::TOKEN_W-1:0]   out_token_reg, out_token_next;
    logic [ctlt_pkg::OWNER_W-1:0]   out_owner_reg, out_owner_next;
    logic [ctlt_pkg::COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                           out_holding_reg, out_holding_next;

    // owner ram ports
    logic                           ram_wr_en;
    logic [IDX_W-1:0]               ram_wr_addr;
    logic [OWN_W-1:0]               ram_wr_data;
    logic                           ram_rd_en;
    logic [IDX_W-1:0]               ram_rd_addr;
    logic [OWN_W-1:0]               ram_rd_data;

    // decode helpers
    logic [ctlt_pkg::ADDR_W-1:0]    fold;
    logic [IDX_W-1:0]               req_idx;
    logic                           req_cpu_ok;
    logic                           req_go_sweep;
    logic [CPU_IW-1:0]              cpu_sel;
    logic [HELD_W-1:0]              held_cur;
    logic                           own_match;
    logic                           owner_free;
    logic                           out_free;
    ctlt_pkg::ctlt_status_t         res_status;
    logic [OWN_W-1:0]               res_owner;

    ctlt_ram #(
        .WIDTH (OWN_W),
        .DEPTH (POOL_SIZE)
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // request decode
    assign fold         = ctlt_pkg::fold_addr(req.resource_address);
    assign req_idx      = fold[IDX_W-1:0];
    assign req_cpu_ok   = int'(req.cpu_number) < CPU_COUNT;
    assign req_go_sweep = (req.opcode == ctlt_pkg::OP_RELEASE_ALL) && req_cpu_ok;

    // owner lookup against the latched cpu
    assign cpu_sel    = CPU_IW'(cpu_reg);
    assign held_cur   = cpu_ok_reg ? held_reg[cpu_sel] : '0;
    assign own_match  = cpu_ok_reg && (int'(ram_rd_data) == int'(cpu_reg));
    assign owner_free = ram_rd_data == FREE_MARK;
    assign out_free   = !out_valid_reg || rsp.ready;

    assign req.ready = state_reg == ctlt_pkg::S_IDLE;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.token_index    = out_token_reg;
    assign rsp.current_owner  = out_owner_reg;
    assign rsp.released_count = out_count_reg;
    assign rsp.is_holding     = out_holding_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctlt_pkg::S_CLEAR:
            begin
                if (cnt_reg[IDX_W-1:0] == IDX_LAST)
                begin
                    state_next = ctlt_pkg::S_IDLE;
                end
            end
            ctlt_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = req_go_sweep ? ctlt_pkg::S_SWEEP : ctlt_pkg::S_EXEC;
                end
            end
            ctlt_pkg::S_SWEEP:
            begin
                if ((cnt_reg == POOL_END) && !chk_vld_reg)
                begin
                    state_next = ctlt_pkg::S_EXEC;
                end
            end
            ctlt_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ctlt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ctlt_pkg::S_CLEAR;
            end
        endcase
    end

    // result of a single token request, from the owner just read
    always_comb
    begin
        res_status = ctlt_pkg::ST_ALL_RELEASED;
        res_owner  = FREE_MARK;
        if (op_reg != ctlt_pkg::OP_RELEASE_ALL)
        begin
            if (null_reg)
            begin
                res_status = ctlt_pkg::ST_NULL_ADDR;
            end
            else
            begin
                res_owner = ram_rd_data;
                unique case (op_reg)
                    ctlt_pkg::OP_ACQUIRE:
                    begin
                        if (own_match)
                        begin
                            res_status = ctlt_pkg::ST_HELD;
                        end
                        else if (!owner_free)
                        begin
                            res_status = ctlt_pkg::ST_BUSY;
                        end
                        else if (!cpu_ok_reg || (held_cur >= HELD_MAX))
                        begin
                            res_status = ctlt_pkg::ST_LIST_FULL;
                        end
                        else
                        begin
                            res_status = ctlt_pkg::ST_GRANTED;
                            res_owner  = OWN_W'(cpu_reg);
                        end
                    end
                    ctlt_pkg::OP_RELEASE:
                    begin
                        if (own_match)
                        begin
                            res_status = ctlt_pkg::ST_RELEASED;
                            res_owner  = FREE_MARK;
                        end
                        else
                        begin
                            res_status = ctlt_pkg::ST_NOT_OWNER;
                        end
                    end
                    ctlt_pkg::OP_QUERY:
                    begin
                        if (own_match)
                        begin
                            res_status = ctlt_pkg::ST_HELD;
                        end
                        else if (!owner_free)
                        begin
                            res_status = ctlt_pkg::ST_BUSY;
                        end
                        else
                        begin
                            res_status = ctlt_pkg::ST_RELEASED;
                        end
                    end
                    default:
                    begin
                        res_status = ctlt_pkg::ST_ALL_RELEASED;
                    end
                endcase
            end
        end
    end

    // datapath, ram control and output register next values
    always_comb
    begin
        cnt_next         = cnt_reg;
        chk_vld_next     = chk_vld_reg;
        chk_addr_next    = chk_addr_reg;
        op_next          = op_reg;
        cpu_next         = cpu_reg;
        cpu_ok_next      = cpu_ok_reg;
        idx_next         = idx_reg;
        null_next        = null_reg;
        rel_next         = rel_reg;
        held_next        = held_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_token_next   = out_token_reg;
        out_owner_next   = out_owner_reg;
        out_count_next   = out_count_reg;
        out_holding_next = out_holding_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = idx_reg;
        ram_wr_data      = FREE_MARK;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = req_idx;

        unique case (state_reg)
            ctlt_pkg::S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cnt_reg[IDX_W-1:0];
                cnt_next    = cnt_reg + 1'b1;
            end
            ctlt_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = ctlt_pkg::ctlt_op_t'(req.opcode);
                    cpu_next     = req.cpu_number;
                    cpu_ok_next  = req_cpu_ok;
                    idx_next     = req_idx;
                    null_next    = req.resource_address == '0;
                    rel_next     = '0;
                    cnt_next     = '0;
                    chk_vld_next = 1'b0;
                    ram_rd_en    = 1'b1;
                end
            end
            ctlt_pkg::S_SWEEP:
            begin
                // check the entry read last cycle while reading the next one
                if (chk_vld_reg && own_match)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = chk_addr_reg;
                    rel_next    = rel_reg + 1'b1;
                end
                if (cnt_reg != POOL_END)
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = cnt_reg[IDX_W-1:0];
                    chk_addr_next = cnt_reg[IDX_W-1:0];
                    chk_vld_next  = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
            end
            ctlt_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status;
                    out_owner_next   = ctlt_pkg::OWNER_W'(res_owner);
                    out_holding_next = 1'b0;
                    out_count_next   = '0;
                    out_token_next   = '0;
                    if (op_reg == ctlt_pkg::OP_RELEASE_ALL)
                    begin
                        out_count_next = (int'(rel_reg) > REL_SAT)
                                       ? ctlt_pkg::COUNT_W'(REL_SAT)
                                       : ctlt_pkg::COUNT_W'(rel_reg);
                        if (cpu_ok_reg)
                        begin
                            held_next[cpu_sel] = '0;
                        end
                    end
                    else if (!null_reg)
                    begin
                        out_token_next   = ctlt_pkg::TOKEN_W'(idx_reg);
                        out_holding_next = cpu_ok_reg
                                        && (int'(res_owner) == int'(cpu_reg));
                        if (res_status == ctlt_pkg::ST_GRANTED)
                        begin
                            ram_wr_en          = 1'b1;
                            ram_wr_data        = res_owner;
                            held_next[cpu_sel] = held_cur + 1'b1;
                        end
                        else if ((op_reg == ctlt_pkg::OP_RELEASE)
                              && (res_status == ctlt_pkg::ST_RELEASED))
                        begin
                            ram_wr_en = 1'b1;
                            if (held_cur != '0)
                            begin
                                held_next[cpu_sel] = held_cur - 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctlt_pkg::S_CLEAR;
            cnt_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CPU_COUNT; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg    <= chk_addr_next;
        op_reg          <= op_next;
        cpu_reg         <= cpu_next;
        cpu_ok_reg      <= cpu_ok_next;
        idx_reg         <= idx_next;
        null_reg        <= null_next;
        rel_reg         <= rel_next;
        out_status_reg  <= out_status_next;
        out_token_reg   <= out_token_next;
        out_owner_reg   <= out_owner_next;
        out_count_reg   <= out_count_next;
        out_holding_reg <= out_holding_next;
    end

    // a result only appears out of the decide cycle
    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ctlt_pkg::S_EXEC)
        else $error("result beat raised outside the decide cycle");

    // a grant always leaves the requester holding the token
    a_grant_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == ctlt_pkg::ST_GRANTED) |-> out_holding_reg)
        else $error("granted token not reported as held");

    // a single token request goes straight from accept to decide
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && !req_go_sweep |=> state_reg == ctlt_pkg::S_EXEC)
        else $error("single token request did not reach the decide cycle");

    // per cpu hold count never passes its limit
    a_held_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cpu_ok_reg |-> held_reg[cpu_sel] <= HELD_MAX)
        else $error("hold count above limit");

    // no ram write while waiting for a request
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ctlt_pkg::S_IDLE |-> !ram_wr_en)
        else $error("owner ram written while idle");

endmodule

@@ dv/ctlt_lock_sb_pkg.sv @@
// ctlt_lock_sb_pkg: scoreboard class for the lock token table, keeps its own
// owner table and per cpu hold counts and queues the answer each request should get
// depends on ctlt_pkg
`timescale 1ns / 1ps

package ctlt_lock_sb_pkg;

    import ctlt_pkg::*;

    localparam int LOCK_POOL     = 64;
    localparam int LOCK_CPUS     = 8;
    localparam int LOCK_MAX_HELD = 16;
    localparam int FREED_SAT     = 31;
    localparam int REPORT_CAP    = 100;

    localparam logic [OWNER_W-1:0] OWNER_FREE = OWNER_W'(LOCK_CPUS);

    typedef struct packed {
        ctlt_status_t         status;
        logic [TOKEN_W-1:0]   token_index;
        logic [OWNER_W-1:0]   current_owner;
        logic [COUNT_W-1:0]   released_count;
        logic                 is_holding;
    } lock_answer_t;

    class lock_table_scoreboard;

        logic [OWNER_W-1:0] token_owner [LOCK_POOL];
        int unsigned        held_tokens [LOCK_CPUS];
        lock_answer_t       lock_answers [$];
        int                 errors;

        function new();
            for (int i = 0; i < LOCK_POOL; i++)
                token_owner[i] = OWNER_FREE;
            for (int c = 0; c < LOCK_CPUS; c++)
                held_tokens[c] = 0;
            errors = 0;
        endfunction

        function int answers_owed();
            return lock_answers.size();
        endfunction

        // only the low index bits of the fold survive, so xor the 6 bit slices
        function int token_of(logic [ADDR_W-1:0] addr);
            logic [TOKEN_W-1:0] slot;
            slot = addr[11:6] ^ addr[17:12] ^ addr[23:18] ^ addr[29:24];
            return int'(slot) % LOCK_POOL;
        endfunction

        function void apply_lock_request(ctlt_op_t op, logic [CPU_W-1:0] cpu,
                                         logic [ADDR_W-1:0] addr);
            lock_answer_t       ans;
            int unsigned        freed;
            bit                 cpu_ok;
            logic [OWNER_W-1:0] me;
            logic [OWNER_W-1:0] owner;
            int                 idx;
            ans = '{status: ST_GRANTED, token_index: '0, current_owner: OWNER_FREE,
                    released_count: '0, is_holding: 1'b0};
            cpu_ok = int'(cpu) < LOCK_CPUS;
            me     = OWNER_W'(cpu);
            if (op == OP_RELEASE_ALL) begin
                freed = 0;
                if (cpu_ok) begin
                    for (int i = 0; i < LOCK_POOL; i++) begin
                        if (token_owner[i] == me) begin
                            token_owner[i] = OWNER_FREE;
                            freed++;
                        end
                    end
                    held_tokens[cpu] = 0;
                end
                ans.status         = ST_ALL_RELEASED;
                ans.released_count = (freed > FREED_SAT) ? COUNT_W'(FREED_SAT)
                                                         : COUNT_W'(freed);
            end else if (addr == '0) begin
                ans.status = ST_NULL_ADDR;
            end else begin
                idx             = token_of(addr);
                ans.token_index = TOKEN_W'(idx);
                owner           = token_owner[idx];
                case (op)
                    OP_ACQUIRE: begin
                        if (cpu_ok && owner == me)
                            ans.status = ST_HELD;
                        else if (owner != OWNER_FREE)
                            ans.status = ST_BUSY;
                        else if (!cpu_ok || held_tokens[cpu] >= LOCK_MAX_HELD)
                            ans.status = ST_LIST_FULL;
                        else begin
                            token_owner[idx] = me;
                            held_tokens[cpu]++;
                            ans.status = ST_GRANTED;
                        end
                    end
                    OP_RELEASE: begin
                        if (cpu_ok && owner == me) begin
                            token_owner[idx] = OWNER_FREE;
                            if (held_tokens[cpu] > 0)
                                held_tokens[cpu]--;
                            ans.status = ST_RELEASED;
                        end else begin
                            ans.status = ST_NOT_OWNER;
                        end
                    end
                    default: begin
                        if (cpu_ok && owner == me)
                            ans.status = ST_HELD;
                        else if (owner != OWNER_FREE)
                            ans.status = ST_BUSY;
                        else
                            ans.status = ST_RELEASED;
                    end
                endcase
                ans.current_owner = token_owner[idx];
                ans.is_holding    = cpu_ok && (token_owner[idx] == me);
            end
            lock_answers.push_back(ans);
        endfunction

        // every mismatch is counted, printing stops after the cap
        task report(string what);
            errors++;
            if (errors <= REPORT_CAP)
                $display("tb: mismatch: %s", what);
        endtask

        task check_lock_answer(lock_answer_t got);
            lock_answer_t ans;
            if (lock_answers.size() == 0) begin
                report($sformatf("result beat with nothing owed, status %0d", got.status));
                return;
            end
            ans = lock_answers.pop_front();
            if (got.status !== ans.status)
                report($sformatf("status got %0d want %0d", got.status, ans.status));
            if (got.token_index !== ans.token_index)
                report($sformatf("token_index got %0d want %0d",
                                 got.token_index, ans.token_index));
            if (got.current_owner !== ans.current_owner)
                report($sformatf("current_owner got %0d want %0d",
                                 got.current_owner, ans.current_owner));
            if (got.released_count !== ans.released_count)
                report($sformatf("released_count got %0d want %0d",
                                 got.released_count, ans.released_count));
            if (got.is_holding !== ans.is_holding)
                report($sformatf("is_holding got %0d want %0d",
                                 got.is_holding, ans.is_holding));
        endtask

    endclass

endpackage

@@ dv/tb.sv @@
// tb: top level testbench for cpu_token_lock_table, directed lock scenarios
// then random request phases under sender idling and receiver stalls
// depends on ctlt_pkg, ctlt_req_if, ctlt_rsp_if, ctlt_lock_sb_pkg
`timescale 1ns / 1ps

module tb;

    import ctlt_pkg::*;
    import ctlt_lock_sb_pkg::*;

    // cycle limit for the whole run, release all sweeps included
    localparam int CYCLE_LIMIT  = 400000;
    // a release all beat needs a full sweep of the owner ram
    localparam int DRAIN_CYCLES = LOCK_POOL + 8;

    logic        clk = 1'b0;
    logic        rst_n;
    int          send_idle_pct;
    int          rsp_stall_pct;
    int unsigned cycle_count = 0;

    lock_table_scoreboard sb;

    ctlt_req_if req_bus ();
    ctlt_rsp_if rsp_bus ();

    cpu_token_lock_table #(
        .POOL_SIZE (LOCK_POOL),
        .CPU_COUNT (LOCK_CPUS),
        .MAX_HELD  (LOCK_MAX_HELD)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // result side backpressure, redrawn every falling edge
    always @(negedge clk)
    begin
        rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // every accepted result beat is checked against the oldest owed answer
    always @(posedge clk)
    begin
        lock_answer_t got;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.status         = ctlt_status_t'(rsp_bus.status);
            got.token_index    = rsp_bus.token_index;
            got.current_owner  = rsp_bus.current_owner;
            got.released_count = rsp_bus.released_count;
            got.is_holding     = rsp_bus.is_holding;
            sb.check_lock_answer(got);
        end
    end

    // random address that folds onto a chosen token; bits 47:30 never reach
    // the index, so one of them keeps the address nonzero
    function automatic logic [ADDR_W-1:0] addr_for_token(int tok);
        logic [ADDR_W-1:0] a;
        a = {16'($urandom), $urandom};
        a[11:6] = TOKEN_W'(tok) ^ a[17:12] ^ a[23:18] ^ a[29:24];
        if (a == '0)
            a[ADDR_W-1] = 1'b1;
        return a;
    endfunction

    // one request beat: optional idle cycles, then hold valid until taken.
    // called and returning on a falling edge
    task automatic drive_request(ctlt_op_t op, logic [CPU_W-1:0] cpu,
                                 logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid            <= 1'b1;
        req_bus.opcode           <= op;
        req_bus.cpu_number       <= cpu;
        req_bus.resource_address <= addr;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        sb.apply_lock_request(op, cpu, addr);
        @(negedge clk);
    endtask

    // directed scenarios: null address on every token op, grant, re-acquire
    // through a colliding address, contention, ownership checks on release
    // and query, hold limit and the release all sweep
    task automatic run_directed();
        drive_request(OP_ACQUIRE, 3'd0, '0);
        drive_request(OP_RELEASE, 3'd0, '0);
        drive_request(OP_QUERY,   3'd0, '0);
        // all ones and one both fold onto token 0
        drive_request(OP_ACQUIRE, 3'd7, {ADDR_W{1'b1}});
        drive_request(OP_ACQUIRE, 3'd7, 48'd1);
        drive_request(OP_ACQUIRE, 3'd0, addr_for_token(0));
        drive_request(OP_QUERY,   3'd7, addr_for_token(0));
        drive_request(OP_QUERY,   3'd0, addr_for_token(0));
        drive_request(OP_RELEASE, 3'd0, addr_for_token(0));
        drive_request(OP_RELEASE, 3'd7, addr_for_token(0));
        drive_request(OP_QUERY,   3'd7, addr_for_token(0));
        // cpu 3 fills its hold list, the next acquire is refused
        for (int t = 1; t <= LOCK_MAX_HELD; t++)
            drive_request(OP_ACQUIRE, 3'd3, addr_for_token(t));
        drive_request(OP_ACQUIRE, 3'd3, addr_for_token(LOCK_MAX_HELD + 1));
        drive_request(OP_RELEASE_ALL, 3'd3, {ADDR_W{1'b1}});
    endtask

    // random traffic; most addresses land on tokens up to tok_hi so cpus
    // collide, some are fully random and a few are null
    task automatic drive_random(int count, int cpu_hi, int tok_hi, int sweep_pct);
        ctlt_op_t          op;
        logic [CPU_W-1:0]  cpu;
        logic [ADDR_W-1:0] addr;
        int                pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < sweep_pct)
                op = OP_RELEASE_ALL;
            else if (pick < 45)
                op = OP_ACQUIRE;
            else if (pick < 70)
                op = OP_RELEASE;
            else
                op = OP_QUERY;
            cpu  = CPU_W'($urandom_range(cpu_hi, 0));
            pick = $urandom_range(99);
            if (pick < 3)
                addr = '0;
            else if (pick < 15)
                addr = {16'($urandom), $urandom};
            else
                addr = addr_for_token($urandom_range(tok_hi, 0));
            drive_request(op, cpu, addr);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n                    = 1'b0;
        req_bus.valid            = 1'b0;
        req_bus.opcode           = OP_ACQUIRE;
        req_bus.cpu_number       = '0;
        req_bus.resource_address = '0;
        rsp_bus.ready            = 1'b0;
        send_idle_pct            = 0;
        rsp_stall_pct            = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // the clearing pass holds req.ready low, the first beat just waits

        run_directed();

        // back to back, eight cpus fighting over a few tokens
        drive_random(120, LOCK_CPUS - 1, 15, 10);

        // sender idles about half the time, whole pool in play
        send_idle_pct = 51;
        rsp_stall_pct = 0;
        drive_random(120, LOCK_CPUS - 1, LOCK_POOL - 1, 10);

        // stop sending until every owed answer is back
        req_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.answers_owed() != 0);

        // receiver stalls about half the time; two cpus and rare sweeps so
        // the hold lists fill up
        send_idle_pct = 0;
        rsp_stall_pct = 51;
        drive_random(130, 1, LOCK_POOL - 1, 1);

        // light idling on both sides
        send_idle_pct = 6;
        rsp_stall_pct = 6;
        drive_random(130, LOCK_CPUS - 1, 15, 10);

        req_bus.valid <= 1'b0;
        while (sb.answers_owed() != 0)
            @(posedge clk);
        // stray beats after the last answer would still be caught here
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.answers_owed() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
